@@ rtl/mandelbrot_escape_time_top_assert.svh @@
// Assertion macros shared by the escape-time block.
// Each macro expects signals named clock and reset in the calling module.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/met_pkg.sv @@
`timescale 1ns / 1ps

package met_pkg;

   // Fixed-point format of the iteration.
   localparam int FRAC_BITS  = 28;
   localparam int COORD_W    = 31;
   localparam int Z_W        = 32;
   localparam int PROD_W     = 2 * Z_W;
   localparam int COUNT_W    = 16;
   localparam int GRAY_W     = 8;
   localparam int DIVIDEND_W = COUNT_W + GRAY_W;

   // Escape threshold 4 at 2*FRAC_BITS fraction bits.
   localparam int TSHIFT = 2 * FRAC_BITS + 2;
   localparam bit NO_ESCAPE = (TSHIFT > PROD_W - 1);
   localparam logic [PROD_W-1:0] THRESH =
      NO_ESCAPE ? '0 : (PROD_W'(1) << TSHIFT);

   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd1000;

   // Size of the queue between the request side and the iteration engine.
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

   // One queued point, already widened to the iteration width.
   typedef struct packed {
      logic signed [Z_W-1:0] c_real;
      logic signed [Z_W-1:0] c_imag;
   } point_type;

   // Request to the gray-level divider.
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [COUNT_W-1:0]    divisor;
   } div_req_type;

   // Answer from the gray-level divider.
   typedef struct packed {
      logic              done;
      logic [GRAY_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/met_front.sv @@
`timescale 1ns / 1ps

module met_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [met_pkg::COORD_W-1:0]     req_c_real,
   input  logic signed [met_pkg::COORD_W-1:0]     req_c_imag,
   output logic                                   q_valid,
   input  logic                                   q_ready,
   output met_pkg::point_type                     q_data
);
   import met_pkg::*;

   point_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_FILL_W-1:0] fill_ff, fill_in;
   logic                    push, pop;
   point_type               incoming;

   // Widen the incoming coordinates to the iteration width.
   always_comb begin
      incoming.c_real = {req_c_real[COORD_W-1], req_c_real};
      incoming.c_imag = {req_c_imag[COORD_W-1], req_c_imag};
   end

   assign req_ready = (fill_ff != QUEUE_FILL_W'(QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_data    = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // Pointer and fill bookkeeping of the queue; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QUEUE_FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QUEUE_FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

@@ rtl/met_divider.sv @@
`timescale 1ns / 1ps

module met_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  met_pkg::div_req_type div_req,
   output met_pkg::div_rsp_type div_rsp
);
   import met_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [2:0]            step_ff, step_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0]    den_ff, den_in;
   logic [GRAY_W-1:0]     quo_ff, quo_in;
   logic [DIVIDEND_W-1:0] trial;

   // The quotient never exceeds eight bits, so eight restoring steps suffice.
   assign trial = DIVIDEND_W'(den_ff) << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = 3'd7;
         rem_in  = div_req.dividend;
         den_in  = div_req.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         // A zero divisor leaves the quotient at zero.
         if (den_ff != '0 && rem_ff >= trial) begin
            rem_in          = rem_ff - trial;
            quo_in[step_ff] = 1'b1;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/met_core.sv @@
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_top_assert.svh"

module met_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [met_pkg::COUNT_W-1:0]   max_iter,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  met_pkg::point_type            q_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [met_pkg::COUNT_W-1:0]   rsp_iter_count,
   output logic                          rsp_bounded,
   output logic [met_pkg::GRAY_W-1:0]    rsp_gray_level
);
   import met_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [Z_W-1:0]    x_ff, x_in, y_ff, y_in, cr_ff, cr_in, ci_ff, ci_in;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, xy_ff, xx_in, yy_in, xy_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     bounded_ff, bounded_in;
   logic [GRAY_W-1:0]        gray_ff, gray_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_bounded_ff, rsp_bounded_in;
   logic [GRAY_W-1:0]        rsp_gray_ff, rsp_gray_in;

   logic [PROD_W-1:0]        mag;
   logic signed [PROD_W-1:0] diff, re_wide, im_wide;
   logic                     limit_hit, escaped, out_free, load_out;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   // Clamp a wide signed value to the iteration width.
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'({1'b0, {(Z_W-1){1'b1}}});
      lo = -hi - PROD_W'(1);
      if (v > hi) begin
         return Z_W'(hi);
      end else if (v < lo) begin
         return Z_W'(lo);
      end
      return Z_W'(v);
   endfunction

   // Full-width squares and cross product of the current z.
   assign xx_in = PROD_W'(x_ff) * PROD_W'(x_ff);
   assign yy_in = PROD_W'(y_ff) * PROD_W'(y_ff);
   assign xy_in = PROD_W'(x_ff) * PROD_W'(y_ff);

   // Escape test and next z from the registered products.
   assign mag       = $unsigned(xx_ff) + $unsigned(yy_ff);
   assign diff      = xx_ff - yy_ff;
   assign re_wide   = (diff >>> FRAC_BITS) + PROD_W'(cr_ff);
   assign im_wide   = (xy_ff >>> (FRAC_BITS - 1)) + PROD_W'(ci_ff);
   assign limit_hit = (count_ff >= max_iter);
   assign escaped   = !NO_ESCAPE && (mag > THRESH);

   assign q_ready  = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (state_ff == S_OUT) && out_free;

   // Gray level request: 255 * count over the limit.
   assign div_req.start    = (state_ff == S_EVAL) && (limit_hit || escaped);
   assign div_req.dividend = {count_ff, {GRAY_W{1'b0}}} - DIVIDEND_W'(count_ff);
   assign div_req.divisor  = max_iter;

   met_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Iteration sequencer.
   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      cr_in      = cr_ff;
      ci_in      = ci_ff;
      count_in   = count_ff;
      bounded_in = bounded_ff;
      gray_in    = gray_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               x_in     = q_data.c_real;
               y_in     = q_data.c_imag;
               cr_in    = q_data.c_real;
               ci_in    = q_data.c_imag;
               count_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (limit_hit) begin
               bounded_in = 1'b1;
               state_in   = S_DIV;
            end else if (escaped) begin
               bounded_in = 1'b0;
               state_in   = S_DIV;
            end else begin
               x_in     = sat_z(re_wide);
               y_in     = sat_z(im_wide);
               count_in = count_ff + COUNT_W'(1);
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               gray_in  = div_rsp.quotient;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register, loaded only when the previous result has left.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_bounded_in = rsp_bounded_ff;
      rsp_gray_in    = rsp_gray_ff;
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_count_in   = count_ff;
         rsp_bounded_in = bounded_ff;
         rsp_gray_in    = gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      cr_ff          <= cr_in;
      ci_ff          <= ci_in;
      count_ff       <= count_in;
      bounded_ff     <= bounded_in;
      gray_ff        <= gray_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_bounded_ff <= rsp_bounded_in;
      rsp_gray_ff    <= rsp_gray_in;
      if (state_ff == S_MUL) begin
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         xy_ff <= xy_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_bounded    = rsp_bounded_ff;
   assign rsp_gray_level = rsp_gray_ff;

   // The count never runs past the limit while iterating.
   `MET_ASSERT_SAME(a_count_le_max, (state_ff == S_MUL || state_ff == S_EVAL),
      (count_ff <= max_iter), "iteration count exceeded the limit")
   // A bounded result always carries the full iteration count.
   `MET_ASSERT_SAME(a_bounded_full, (rsp_valid_ff && rsp_bounded_ff),
      (rsp_count_ff == max_iter), "bounded result with short count")
   // An escaped result stopped below the limit.
   `MET_ASSERT_SAME(a_escaped_short, (rsp_valid_ff && !rsp_bounded_ff),
      (rsp_count_ff < max_iter), "escaped result at or above the limit")
   // The divider only finishes while the sequencer waits for it.
   `MET_ASSERT_SAME(a_div_done_state, div_rsp.done, (state_ff == S_DIV),
      "divider finished outside the wait state")
   // Starting a division always moves the sequencer into the wait state.
   `MET_ASSERT_NEXT(a_div_start_wait, div_req.start, (state_ff == S_DIV),
      "division started without waiting for it")

endmodule

@@ rtl/mandelbrot_escape_time_top.sv @@
`timescale 1ns / 1ps
// Mandelbrot escape-time unit.
// Request channel (req_valid/req_ready): one point c as signed Q3.28 real and
// imaginary parts. Response channel (rsp_valid/rsp_ready): iteration count,
// bounded flag and gray level 255*count/max_iter for each point, in order.
// Configuration: csr_wr_en with csr_wr_data writes the iteration limit at once;
// write it only while no point is in flight.
// A two-entry queue takes points while the iteration engine works, so the
// request side keeps flowing while a result waits in the output register.
// Each iteration runs through the product register and then the escape test
// and update. A point passes from request transaction to response
// transaction through queue entry, the iterations, one final test, eight
// divider steps, the quotient capture and the output load. Points are
// processed one at a time; a waiting point starts once the previous one has
// left the engine.
// Reset empties the queue, drops any point in flight and any pending result,
// and sets the limit to 1000. When the receiver stalls, the result holds in
// the output register; the engine finishes the next point and then waits,
// and the queue fills and deasserts req_ready.
module mandelbrot_escape_time_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [met_pkg::COORD_W-1:0]   req_c_real,
   input  logic signed [met_pkg::COORD_W-1:0]   req_c_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [met_pkg::COUNT_W-1:0]          rsp_iter_count,
   output logic                                 rsp_bounded,
   output logic [met_pkg::GRAY_W-1:0]           rsp_gray_level,
   input  logic                                 csr_wr_en,
   input  logic [met_pkg::COUNT_W-1:0]          csr_wr_data
);
   import met_pkg::*;

   logic [COUNT_W-1:0] max_iter_ff, max_iter_in;
   logic               q_valid, q_ready;
   point_type          q_data;

   // Iteration limit register.
   assign max_iter_in = csr_wr_en ? csr_wr_data : max_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   met_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_c_real (req_c_real),
      .req_c_imag (req_c_imag),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_data     (q_data)
   );

   met_core u_core (
      .clock          (clock),
      .reset          (reset),
      .max_iter       (max_iter_ff),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_data         (q_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_iter_count (rsp_iter_count),
      .rsp_bounded    (rsp_bounded),
      .rsp_gray_level (rsp_gray_level)
   );

endmodule
